/* hw/rtl/mss_pkg.sv */
`timescale 1ns / 1ps
package mss_pkg;

    localparam int MAX_BINS   = 1048576;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_W      = 21;
    localparam int DATA_W     = 64;
    localparam int STEP_W     = 7;
    localparam int ROOT_W     = 32;

    localparam logic [STEP_W-1:0] DIV_STEPS_MEAN = STEP_W'(32);
    localparam logic [STEP_W-1:0] DIV_STEPS_FULL = STEP_W'(64);

    // configuration register indexes
    localparam logic [1:0] CFG_INCLUDE_GLUED = 2'd0;
    localparam logic [1:0] CFG_VARIANCE_ALL  = 2'd1;
    localparam logic [1:0] CFG_ERROR_SCALE   = 2'd2;

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_ERR_SCALE  = 14'b00000000000010,
        S_ERR_SQUARE = 14'b00000000000100,
        S_ERR_ADD    = 14'b00000000001000,
        S_VAR_DIV    = 14'b00000000010000,
        S_VAR_MEAN   = 14'b00000000100000,
        S_VAR_PROD   = 14'b00000001000000,
        S_VAR_ADD    = 14'b00000010000000,
        S_FIN_START  = 14'b00000100000000,
        S_FIN_VDIV   = 14'b00001000000000,
        S_FIN_VSQRT  = 14'b00010000000000,
        S_FIN_EDIV   = 14'b00100000000000,
        S_FIN_ESQRT  = 14'b01000000000000,
        S_OUT        = 14'b10000000000000
    } state_t;

endpackage

/* hw/rtl/masked_surface_statistics.sv */
`timescale 1ns / 1ps
// sequence: a bin goes through scale, square and add, then, when it enters the variance, a mean
// division, mean update, product and add; a last bin then adds two divisions and two roots
// for bins in the variance the pace is set by the shared restoring divider in the mean update
// the input is not ready while a bin is being worked; a finished result waits in the output
// register while the next bins stream in
// reset: asynchronous active low, clears accumulators and sets error_scale to 1.0 (256)
module masked_surface_statistics (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    // bin stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // energy, error_value, sample_count
    input  logic         s_tlast,   // last bin of the surface
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata    // variance, std_dev, rms_error, max_error, min_energy,
                                    // bins_used, zero pad
);

    localparam int FB = mss_pkg::FRAC_BITS;
    localparam int CW = mss_pkg::CNT_W;

    mss_pkg::state_t state_reg, state_next;

    // configuration
    logic        glued_reg;
    logic        var_all_reg;
    logic [15:0] scale_reg;

    // captured bin
    logic signed [31:0] energy_reg;
    logic signed [31:0] err_reg;
    logic               pass_reg;
    logic               vtake_reg;
    logic               last_reg;

    // accumulators
    logic [CW-1:0]      var_count_reg, var_count_next;
    logic signed [31:0] mean_reg, mean_next;
    logic [63:0]        m2_reg, m2_next;
    logic [CW-1:0]      err_count_reg, err_count_next;
    logic [63:0]        err_sum_reg, err_sum_next;
    logic [30:0]        peak_reg, peak_next;
    logic signed [31:0] floor_reg, floor_next;
    logic               seen_reg, seen_next;

    // working values
    logic [63:0] prod_reg;
    logic        d1_neg_reg;
    logic [31:0] d1_abs_reg;
    logic [63:0] var_q_reg;
    logic [31:0] sd_reg;
    logic [31:0] rms_reg;

    // result register
    logic         m_tvalid_reg;
    logic [195:0] m_data_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] product;

    // divider and root unit
    logic                        div_start;
    logic [mss_pkg::STEP_W-1:0]  div_steps;
    logic [63:0]                 div_dividend;
    logic [CW-1:0]               div_divisor;
    logic [63:0]                 div_quot;
    logic                        div_done;
    logic                        sqrt_start;
    logic [63:0]                 sqrt_rad;
    logic [31:0]                 sqrt_root;
    logic                        sqrt_done;

    logic               in_fire;
    logic signed [31:0] in_energy, in_count;
    logic [31:0]        err_abs;
    logic [38:0]        mag;
    logic [31:0]        mag_cap;
    logic [30:0]        mag_peak;
    logic signed [32:0] d_cur;
    logic [31:0]        d_cur_abs;
    logic [64:0]        sum_err;
    logic [64:0]        sum_m2;
    logic signed [33:0] mean_sum;
    logic [33:0]        q_ext;
    logic               out_free;

    assign in_fire   = s_tvalid && s_tready;
    assign in_energy = s_tdata[31:0];
    assign in_count  = s_tdata[95:64];
    assign s_tready  = (state_reg == mss_pkg::S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign err_abs  = err_reg[31] ? 32'(~err_reg + 32'sd1) : err_reg;
    assign mag      = prod_reg[46:8];
    assign mag_cap  = (|mag[38:32]) ? 32'hFFFF_FFFF : mag[31:0];
    assign mag_peak = (|mag[38:31]) ? 31'h7FFF_FFFF : mag[30:0];

    // distance of the bin energy from the current mean
    assign d_cur     = {energy_reg[31], energy_reg} - {mean_reg[31], mean_reg};
    assign d_cur_abs = d_cur[32] ? 32'(-d_cur) : d_cur[31:0];

    assign sum_err  = {1'b0, err_sum_reg} + {17'b0, prod_reg[63:FB]};
    assign sum_m2   = {1'b0, m2_reg} + {17'b0, prod_reg[63:FB]};
    assign q_ext    = {2'b00, div_quot[31:0]};
    assign mean_sum = {{2{mean_reg[31]}}, mean_reg}
                    + (d1_neg_reg ? -$signed(q_ext) : $signed(q_ext));

    // multiplier operand selection
    always_comb
    begin
        mul_a = d1_abs_reg;
        mul_b = d_cur_abs;
        if (state_reg == mss_pkg::S_ERR_SCALE)
        begin
            mul_a = err_abs;
            mul_b = {16'b0, scale_reg};
        end
        else if (state_reg == mss_pkg::S_ERR_SQUARE)
        begin
            mul_a = mag_cap;
            mul_b = mag_cap;
        end
    end
    assign product = mul_a * mul_b;

    // divider request: mean step, then variance and error sums at the end of a surface
    always_comb
    begin
        div_start    = 1'b0;
        div_steps    = mss_pkg::DIV_STEPS_FULL;
        div_dividend = m2_reg;
        div_divisor  = var_count_reg;
        if (state_reg == mss_pkg::S_ERR_ADD && vtake_reg)
        begin
            div_start    = 1'b1;
            div_steps    = mss_pkg::DIV_STEPS_MEAN;
            div_dividend = {d_cur_abs, 32'b0};
            div_divisor  = var_count_reg + 1'b1;
        end
        else if (state_reg == mss_pkg::S_FIN_START)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == mss_pkg::S_FIN_VSQRT && sqrt_done)
        begin
            div_start    = 1'b1;
            div_dividend = err_sum_reg;
            div_divisor  = err_count_reg;
        end
    end

    // root of a Q value: radicand shifted up by the fraction bits
    assign sqrt_start = ((state_reg == mss_pkg::S_FIN_VDIV) || (state_reg == mss_pkg::S_FIN_EDIV))
                        && div_done;
    assign sqrt_rad   = div_quot << FB;

    mss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    mss_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    // sequencer and accumulator updates
    always_comb
    begin
        state_next     = state_reg;
        var_count_next = var_count_reg;
        mean_next      = mean_reg;
        m2_next        = m2_reg;
        err_count_next = err_count_reg;
        err_sum_next   = err_sum_reg;
        peak_next      = peak_reg;
        floor_next     = floor_reg;
        seen_next      = seen_reg;
        unique case (state_reg)
            mss_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    // minimum energy over every bin with a nonzero count
                    if (in_count != 32'sd0 && (!seen_reg || in_energy < floor_reg))
                    begin
                        floor_next = in_energy;
                        seen_next  = 1'b1;
                    end
                    state_next = mss_pkg::S_ERR_SCALE;
                end
            end
            mss_pkg::S_ERR_SCALE:
                state_next = mss_pkg::S_ERR_SQUARE;
            mss_pkg::S_ERR_SQUARE:
            begin
                // peak only from positive scaled errors
                if (pass_reg && !err_reg[31] && err_reg != 32'sd0 && mag != '0
                    && mag_peak > peak_reg)
                    peak_next = mag_peak;
                state_next = mss_pkg::S_ERR_ADD;
            end
            mss_pkg::S_ERR_ADD:
            begin
                if (pass_reg && err_count_reg < CW'(mss_pkg::MAX_BINS))
                begin
                    err_count_next = err_count_reg + 1'b1;
                    err_sum_next   = sum_err[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_err[63:0];
                end
                if (vtake_reg)
                begin
                    var_count_next = var_count_reg + 1'b1;
                    state_next     = mss_pkg::S_VAR_DIV;
                end
                else
                    state_next = last_reg ? mss_pkg::S_FIN_START : mss_pkg::S_IDLE;
            end
            mss_pkg::S_VAR_DIV:
            begin
                if (div_done)
                    state_next = mss_pkg::S_VAR_MEAN;
            end
            mss_pkg::S_VAR_MEAN:
            begin
                mean_next  = mean_sum[31:0];
                state_next = mss_pkg::S_VAR_PROD;
            end
            mss_pkg::S_VAR_PROD:
                state_next = mss_pkg::S_VAR_ADD;
            mss_pkg::S_VAR_ADD:
            begin
                m2_next    = sum_m2[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_m2[63:0];
                state_next = last_reg ? mss_pkg::S_FIN_START : mss_pkg::S_IDLE;
            end
            mss_pkg::S_FIN_START:
                state_next = mss_pkg::S_FIN_VDIV;
            mss_pkg::S_FIN_VDIV:
            begin
                if (div_done)
                    state_next = mss_pkg::S_FIN_VSQRT;
            end
            mss_pkg::S_FIN_VSQRT:
            begin
                if (sqrt_done)
                    state_next = mss_pkg::S_FIN_EDIV;
            end
            mss_pkg::S_FIN_EDIV:
            begin
                if (div_done)
                    state_next = mss_pkg::S_FIN_ESQRT;
            end
            mss_pkg::S_FIN_ESQRT:
            begin
                if (sqrt_done)
                    state_next = mss_pkg::S_OUT;
            end
            mss_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    // surface done, start the next one clean
                    var_count_next = '0;
                    mean_next      = '0;
                    m2_next        = '0;
                    err_count_next = '0;
                    err_sum_next   = '0;
                    peak_next      = '0;
                    floor_next     = '0;
                    seen_next      = 1'b0;
                    state_next     = mss_pkg::S_IDLE;
                end
            end
            default:
                state_next = mss_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::S_IDLE;
            glued_reg     <= 1'b0;
            var_all_reg   <= 1'b0;
            scale_reg     <= 16'd256;
            var_count_reg <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            err_count_reg <= '0;
            err_sum_reg   <= '0;
            peak_reg      <= '0;
            floor_reg     <= '0;
            seen_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            var_count_reg <= var_count_next;
            mean_reg      <= mean_next;
            m2_reg        <= m2_next;
            err_count_reg <= err_count_next;
            err_sum_reg   <= err_sum_next;
            peak_reg      <= peak_next;
            floor_reg     <= floor_next;
            seen_reg      <= seen_next;
            if (cfg_we)
            begin
                if (cfg_index == mss_pkg::CFG_INCLUDE_GLUED)
                    glued_reg <= cfg_wdata[0];
                else if (cfg_index == mss_pkg::CFG_VARIANCE_ALL)
                    var_all_reg <= cfg_wdata[0];
                else if (cfg_index == mss_pkg::CFG_ERROR_SCALE)
                    scale_reg <= cfg_wdata;
            end
            if (state_reg == mss_pkg::S_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            energy_reg <= in_energy;
            err_reg    <= s_tdata[63:32];
            last_reg   <= s_tlast;
            // sample filter: sampled bins, glued bins when enabled
            pass_reg   <= (in_count > 32'sd0) || (in_count < 32'sd0 && glued_reg);
            vtake_reg  <= ((in_count > 32'sd0) || (in_count < 32'sd0 && glued_reg)
                           || var_all_reg) && (var_count_reg < CW'(mss_pkg::MAX_BINS));
        end
        if (state_reg == mss_pkg::S_ERR_SCALE || state_reg == mss_pkg::S_ERR_SQUARE
            || state_reg == mss_pkg::S_VAR_PROD)
            prod_reg <= product;
        if (state_reg == mss_pkg::S_ERR_ADD)
        begin
            d1_neg_reg <= d_cur[32];
            d1_abs_reg <= d_cur_abs;
        end
        if (state_reg == mss_pkg::S_FIN_VDIV && div_done)
            var_q_reg <= div_quot;
        if (state_reg == mss_pkg::S_FIN_VSQRT && sqrt_done)
            sd_reg <= (|div_quot[63:64-FB]) ? 32'hFFFF_FFFF : sqrt_root;
        if (state_reg == mss_pkg::S_FIN_ESQRT && sqrt_done)
            rms_reg <= (|div_quot[63:64-FB]) ? 32'hFFFF_FFFF : sqrt_root;
        if (state_reg == mss_pkg::S_OUT && out_free)
        begin
            m_data_reg[47:0]    <= (var_count_reg == '0) ? 48'd0 :
                                   ((|var_q_reg[63:48]) ? 48'hFFFF_FFFF_FFFF : var_q_reg[47:0]);
            m_data_reg[79:48]   <= (var_count_reg == '0) ? 32'd0 : sd_reg;
            m_data_reg[111:80]  <= (err_count_reg == '0) ? 32'd0 : rms_reg;
            m_data_reg[142:112] <= peak_reg;
            m_data_reg[174:143] <= seen_reg ? floor_reg : 32'sd0;
            m_data_reg[195:175] <= err_count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_data_reg};

endmodule

/* hw/rtl/mss_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module mss_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mss_pkg::STEP_W-1:0]    steps,
    input  logic [mss_pkg::DATA_W-1:0]    dividend,
    input  logic [mss_pkg::CNT_W-1:0]     divisor,
    output logic [mss_pkg::DATA_W-1:0]    quotient,
    output logic                          done
);

    logic [mss_pkg::DATA_W-1:0] num_reg, num_next;
    logic [mss_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [mss_pkg::CNT_W-1:0]  den_reg, den_next;
    logic [mss_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [mss_pkg::CNT_W:0]    trial;
    logic [mss_pkg::CNT_W:0]    diff;

    assign trial = {rem_reg, num_reg[mss_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = steps;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[mss_pkg::CNT_W-1:0];
                num_next = {num_reg[mss_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[mss_pkg::CNT_W-1:0];
                num_next = {num_reg[mss_pkg::DATA_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == mss_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = num_reg;
    assign done     = done_reg;

endmodule

/* hw/rtl/mss_sqrt.sv */
`timescale 1ns / 1ps
// digit-by-digit square root, one root bit per cycle
module mss_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mss_pkg::DATA_W-1:0]    radicand,
    output logic [mss_pkg::ROOT_W-1:0]    root,
    output logic                          done
);

    localparam int REM_W = mss_pkg::ROOT_W + 2;

    logic [mss_pkg::DATA_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [mss_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [REM_W+1:0]           shifted;
    logic [REM_W+1:0]           test;

    assign shifted = {rem_reg, rad_reg[mss_pkg::DATA_W-1 -: 2]};
    assign test    = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[mss_pkg::DATA_W-3:0], 2'b00};
            if (shifted >= test)
            begin
                rem_next  = REM_W'(shifted - test);
                root_next = {root_reg[mss_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[REM_W-1:0];
                root_next = {root_reg[mss_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'(mss_pkg::ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* tb/masked_surface_statistics_tb.sv */
`timescale 1ns / 1ps
module masked_surface_statistics_tb;

    localparam int  SETTLE_CYCLES = 400;      // longer than a last bin's full latency
    localparam int  HOLD_CYCLES   = 1500;     // long output hold-off, several surfaces' worth
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK48     = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK32     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] PEAK_MAX   = 64'h0000_0000_7FFF_FFFF;
    // register index with no register behind it
    localparam logic [1:0]  CFG_UNUSED = 2'd3;

    // one grid bin as it travels on the input stream
    typedef struct packed {
        logic        last;
        logic [31:0] sample_count;
        logic [31:0] error_value;
        logic [31:0] energy;
    } bin_t;

    // one surface summary as it travels on the output stream
    typedef struct packed {
        logic [20:0] bins_used;
        logic [31:0] min_energy;
        logic [30:0] max_error;
        logic [31:0] rms_error;
        logic [31:0] std_dev;
        logic [47:0] variance;
    } stats_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;   // energy, error_value, sample_count
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;        // variance, std_dev, rms_error, max_error, min_energy,
                                  // bins_used, zero pad

    masked_surface_statistics DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    // bins waiting to be sent, summaries waiting to be seen
    bin_t   pending_bins[$];
    stats_t expected_stats[$];

    int     mismatches = 0;
    int     bins_sent = 0;
    int     surfaces_checked = 0;
    longint cycle_count = 0;
    bit     in_taken = 1'b0;
    bit     quiet = 1'b0;
    bit     hold_req = 1'b0;
    bit     hold_used = 1'b0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     hold_left = 0;

    // shadow of the configuration registers
    bit          glued_on = 1'b0;
    bit          var_every_bin = 1'b0;
    logic [15:0] err_scale = 16'd256;

    // shadow of the surface accumulators
    logic [31:0]        var_n;
    longint             mean_q;
    logic [63:0]        m2_q;
    logic [31:0]        err_n;
    logic [63:0]        err_sq_sum;
    logic [31:0]        err_peak_q;
    logic signed [31:0] energy_low;
    bit                 energy_low_seen;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES64 : s[63:0];
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bit_q;
        r = 0;
        bit_q = 64'd1 << 62;
        while (bit_q > x)
            bit_q = bit_q >> 2;
        while (bit_q != 0)
        begin
            if (x >= r + bit_q)
            begin
                x = x - (r + bit_q);
                r = (r >> 1) + bit_q;
            end
            else
                r = r >> 1;
            bit_q = bit_q >> 2;
        end
        return r;
    endfunction

    // fixed point square root, saturating at 32 bits
    function automatic logic [63:0] fixed_root(logic [63:0] v);
        logic [63:0] r;
        if ((v >> (64 - mss_pkg::FRAC_BITS)) != 0)
            return MASK32;
        r = int_root(v << mss_pkg::FRAC_BITS);
        return (r > MASK32) ? MASK32 : r;
    endfunction

    function automatic void clear_surface();
        var_n = 0;
        mean_q = 0;
        m2_q = 0;
        err_n = 0;
        err_sq_sum = 0;
        err_peak_q = 0;
        energy_low = 0;
        energy_low_seen = 1'b0;
    endfunction

    // fold one bin into the surface shadow; on the last bin queue the expected summary
    function automatic void fold_bin(bin_t b);
        longint      e;
        longint      er;
        longint      cnt;
        longint      d1;
        longint      d2;
        logic [63:0] a1;
        logic [63:0] a2;
        logic [63:0] mag;
        logic [63:0] cap;
        logic [63:0] q;
        bit          pass;
        stats_t      s;
        e   = longint'($signed(b.energy));
        er  = longint'($signed(b.error_value));
        cnt = longint'($signed(b.sample_count));
        pass = (cnt > 0) || (cnt < 0 && glued_on);

        // minimum energy looks at every bin with samples or glue
        if (cnt != 0 && (!energy_low_seen || e < longint'(energy_low)))
        begin
            energy_low = b.energy;
            energy_low_seen = 1'b1;
        end

        // welford update, mean quotient truncated toward zero
        if ((pass || var_every_bin) && var_n < mss_pkg::MAX_BINS)
        begin
            var_n = var_n + 1;
            d1 = e - mean_q;
            mean_q = mean_q + d1 / longint'(var_n);
            d2 = e - mean_q;
            a1 = (d1 < 0) ? -d1 : d1;
            a2 = (d2 < 0) ? -d2 : d2;
            m2_q = sat_sum(m2_q, (a1 * a2) >> mss_pkg::FRAC_BITS);
        end

        if (pass)
        begin
            mag = ((er < 0) ? -er : er);
            mag = (mag * {48'd0, err_scale}) >> 8;
            cap = (mag > MASK32) ? MASK32 : mag;
            // only positive errors raise the peak
            if (er > 0 && mag > 0)
            begin
                if (((mag > PEAK_MAX) ? PEAK_MAX : mag) > {32'd0, err_peak_q})
                    err_peak_q = (mag > PEAK_MAX) ? PEAK_MAX[31:0] : mag[31:0];
            end
            if (err_n < mss_pkg::MAX_BINS)
            begin
                err_n = err_n + 1;
                err_sq_sum = sat_sum(err_sq_sum, (cap * cap) >> mss_pkg::FRAC_BITS);
            end
        end

        if (b.last)
        begin
            s = '0;
            // empty surface leaves variance, deviation and rms at zero
            if (var_n != 0)
            begin
                q = m2_q / {32'd0, var_n};
                s.variance = (q > MASK48) ? MASK48[47:0] : q[47:0];
                s.std_dev = 32'(fixed_root(q));
            end
            if (err_n != 0)
                s.rms_error = 32'(fixed_root(err_sq_sum / {32'd0, err_n}));
            s.max_error = err_peak_q[30:0];
            s.min_energy = energy_low_seen ? energy_low : 32'd0;
            s.bins_used = err_n[20:0];
            expected_stats = {expected_stats, s};
            clear_surface();
        end
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("surface %0d: %s got %0h, expected %0h", surfaces_checked, field, got, want);
    endtask

    // monitor: both handshakes are sampled at the rising edge
    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
        in_taken = s_tvalid && s_tready;
        if (in_taken)
        begin
            fold_bin({s_tlast, s_tdata});
            bins_sent++;
        end
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(stats_t)-1:0];
            if (expected_stats.size() == 0)
                report_mismatch("unexpected summary", 64'(got.variance), 64'd0);
            else
            begin
                want = expected_stats.pop_front();
                if (got.variance !== want.variance)
                    report_mismatch("variance", 64'(got.variance), 64'(want.variance));
                if (got.std_dev !== want.std_dev)
                    report_mismatch("std_dev", 64'(got.std_dev), 64'(want.std_dev));
                if (got.rms_error !== want.rms_error)
                    report_mismatch("rms_error", 64'(got.rms_error), 64'(want.rms_error));
                if (got.max_error !== want.max_error)
                    report_mismatch("max_error", 64'(got.max_error), 64'(want.max_error));
                if (got.min_energy !== want.min_energy)
                    report_mismatch("min_energy", 64'(got.min_energy), 64'(want.min_energy));
                if (got.bins_used !== want.bins_used)
                    report_mismatch("bins_used", 64'(got.bins_used), 64'(want.bins_used));
                surfaces_checked++;
            end
        end
    end

    // driver: offers the next bin at the falling edge, with random idle bursts
    always @(negedge clk)
    begin
        bin_t b;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_bins.size() != 0 && !quiet && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end
            else if (pending_bins.size() != 0)
            begin
                b = pending_bins.pop_front();
                s_tdata <= {b.sample_count, b.error_value, b.energy};
                s_tlast <= b.last;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            recv_gap = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mss_pkg::CFG_INCLUDE_GLUED: glued_on = value[0];
            mss_pkg::CFG_VARIANCE_ALL:  var_every_bin = value[0];
            mss_pkg::CFG_ERROR_SCALE:   err_scale = value;
            default: ;
        endcase
    endtask

    task automatic set_config(bit glued, bit every, logic [15:0] scale);
        write_reg(mss_pkg::CFG_INCLUDE_GLUED, 16'(glued));
        write_reg(mss_pkg::CFG_VARIANCE_ALL, 16'(every));
        write_reg(mss_pkg::CFG_ERROR_SCALE, scale);
        // unused register index must be ignored
        write_reg(CFG_UNUSED, 16'($urandom));
    endtask

    // block is idle once every bin is in, every summary out and the pipeline drained
    task automatic drain();
        while (pending_bins.size() != 0 || s_tvalid || expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_bin(logic [31:0] e, logic [31:0] er, logic [31:0] cnt, bit last);
        bin_t b;
        b.energy = e;
        b.error_value = er;
        b.sample_count = cnt;
        b.last = last;
        pending_bins = {pending_bins, b};
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                                 : 32'h8000_0000 + $urandom_range(0, 15);
            default: return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh1F_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1:    return 32'd0;
            2, 3:    return -32'($urandom_range(1, 1000));
            4:       return $urandom;
            5:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    // well-formed surfaces of random length, each closed by a last bin
    task automatic add_surfaces(int n_bins);
        int len;
        int i;
        while (n_bins > 0)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            for (i = 0; i < len; i++)
                add_bin(pick_value(), pick_value(), pick_count(), i == len - 1);
            n_bins -= len;
        end
    endtask

    task automatic add_directed();
        // field extremes in one surface
        add_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0);
        add_bin(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_bin(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        add_bin(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1);
        // single bin surface
        add_bin(32'h0003_0000, 32'h0000_8000, 32'd7, 1'b1);
        // no sampled bins: only zero counts
        add_bin(32'h1234_5678, 32'h0100_0000, 32'd0, 1'b0);
        add_bin(32'h8000_0000, 32'h0100_0000, 32'd0, 1'b1);
        // glued only: filtered unless glued bins are on, minimum still sees them
        add_bin(32'hFFF0_0000, 32'h0002_0000, -32'd3, 1'b0);
        add_bin(32'h0010_0000, 32'h0001_0000, -32'd1, 1'b1);
        // only negative errors leave the peak at zero
        add_bin(32'h0001_0000, 32'hFFFF_0000, 32'd2, 1'b0);
        add_bin(32'h0002_0000, 32'h8000_0000, 32'd4, 1'b0);
        add_bin(32'h0004_0000, 32'hFFFF_FFFF, 32'd9, 1'b1);
        // constant energy gives zero variance
        add_bin(32'h0005_0000, 32'h0000_0001, 32'd1, 1'b0);
        add_bin(32'h0005_0000, 32'h0000_0002, 32'd1, 1'b0);
        add_bin(32'h0005_0000, 32'h0000_0003, 32'd1, 1'b1);
        // widely spread energies push the accumulators toward saturation
        add_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0);
        add_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0);
        add_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0);
        add_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b1);
    endtask

    initial
    begin
        clear_surface();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings first
        add_directed();
        drain();

        set_config(1'b1, 1'b0, 16'hFFFF);
        add_directed();
        add_surfaces(300);
        drain();

        // every bin in the variance, zero scale; long output hold-off while bins flow
        set_config(1'b0, 1'b1, 16'h0000);
        add_directed();
        add_surfaces(350);
        @(posedge clk);
        hold_req = 1'b1;
        drain();

        set_config(1'b1, 1'b1, 16'h0001);
        add_surfaces(350);
        drain();

        set_config(1'b0, 1'b0, 16'($urandom_range(1, 65534)));
        add_surfaces(350);
        drain();

        set_config(1'b1, 1'b0, 16'h0100);
        add_surfaces(300);
        drain();

        // closing stretch with no idling on either side
        quiet = 1'b1;
        set_config(1'($urandom), 1'($urandom), 16'($urandom));
        add_surfaces(350);
        drain();

        $display("run covered %0d bins and %0d surface summaries over 7 register settings",
                 bins_sent, surfaces_checked);
        $display("including field extremes, empty and glued surfaces and a long output stall");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
